// ===== design/sdc_pkg.sv =====
// Shared types and constants for the scaled decimal compare block.
// Used by the alignment datapath and the top-level sequencer; no dependencies.

package sdc_pkg;

    localparam int MANT_LOW_BITS  = 64;
    localparam int MANT_HIGH_BITS = 32;
    localparam int MANT_BITS      = MANT_LOW_BITS + MANT_HIGH_BITS;
    localparam int SCALE_BITS     = 5;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ALIGN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0]
    {
        ORDER_LESS    = 2'd0,
        ORDER_EQUAL   = 2'd1,
        ORDER_GREATER = 2'd2
    } order_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed
    {
        logic load;
        logic step;
    } dp_ctrl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed
    {
        logic aligned;
        logic a_neg;
        logic b_neg;
        logic mag_lt;
        logic mag_eq;
    } dp_status_t;

endpackage

// ===== design/sdc_align_dp.sv =====
// Operand registers, shared multiply-by-ten unit and magnitude compare.
// Depends on sdc_pkg for the control and status structs and field widths.

module sdc_align_dp #(
    parameter int WIDE_BITS = 224
) (
    input  logic                                    clk,
    input  sdc_pkg::dp_ctrl_t                       ctrl,
    input  logic [sdc_pkg::MANT_LOW_BITS-1:0]       a_mant_low,
    input  logic [sdc_pkg::MANT_HIGH_BITS-1:0]      a_mant_high,
    input  logic [sdc_pkg::SCALE_BITS-1:0]          a_scale,
    input  logic                                    a_negative,
    input  logic [sdc_pkg::MANT_LOW_BITS-1:0]       b_mant_low,
    input  logic [sdc_pkg::MANT_HIGH_BITS-1:0]      b_mant_high,
    input  logic [sdc_pkg::SCALE_BITS-1:0]          b_scale,
    input  logic                                    b_negative,
    output sdc_pkg::dp_status_t                     status
);

    localparam int PAD_BITS = WIDE_BITS - sdc_pkg::MANT_BITS;

    logic [WIDE_BITS-1:0]             a_reg, a_next;
    logic [WIDE_BITS-1:0]             b_reg, b_next;
    logic [sdc_pkg::SCALE_BITS-1:0]   sa_reg, sa_next;
    logic [sdc_pkg::SCALE_BITS-1:0]   sb_reg, sb_next;
    logic                             na_reg, na_next;
    logic                             nb_reg, nb_next;

    logic                             pick_a;
    logic [WIDE_BITS-1:0]             mul_in;
    logic [WIDE_BITS-1:0]             mul_out;

    // The operand with the smaller scale is the one that gets scaled up.
    assign pick_a  = (sa_reg < sb_reg);
    assign mul_in  = pick_a ? a_reg : b_reg;
    // x*10 = x*2 + x*8, wrapping at the register width.
    assign mul_out = {mul_in[WIDE_BITS-2:0], 1'b0} + {mul_in[WIDE_BITS-4:0], 3'b000};

    always_comb
    begin
        a_next  = a_reg;
        b_next  = b_reg;
        sa_next = sa_reg;
        sb_next = sb_reg;
        na_next = na_reg;
        nb_next = nb_reg;
        if (ctrl.load)
        begin
            a_next  = {{PAD_BITS{1'b0}}, a_mant_high, a_mant_low};
            b_next  = {{PAD_BITS{1'b0}}, b_mant_high, b_mant_low};
            sa_next = a_scale;
            sb_next = b_scale;
            na_next = a_negative;
            nb_next = b_negative;
        end
        else if (ctrl.step)
        begin
            if (pick_a)
            begin
                a_next  = mul_out;
                sa_next = sa_reg + 1'b1;
            end
            else
            begin
                b_next  = mul_out;
                sb_next = sb_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        sa_reg <= sa_next;
        sb_reg <= sb_next;
        na_reg <= na_next;
        nb_reg <= nb_next;
    end

    // A zero magnitude counts as non-negative, whatever its sign bit.
    assign status.aligned = (sa_reg == sb_reg);
    assign status.a_neg   = na_reg && (|a_reg);
    assign status.b_neg   = nb_reg && (|b_reg);
    assign status.mag_lt  = (a_reg < b_reg);
    assign status.mag_eq  = (a_reg == b_reg);

endmodule

// ===== design/scaled_decimal_compare_core.sv =====
// Top level of the scaled decimal compare block: sequencer and result register.
// Depends on sdc_pkg and instantiates sdc_align_dp.
//
// Orders two scaled decimals (96-bit mantissa, power-of-ten scale, sign) and
// returns less, equal or greater, with negative zero equal to positive zero.
// One transfer runs from acceptance through loading, the alignment steps and
// the finishing state to the result being offered, and it waits longer while
// the previous result is still held in the result register. The alignment is
// done by the single shared multiply-by-ten adder, which scales up the operand
// with the smaller scale by one decade per cycle. The input is stalled while an
// item is being worked on and is free again in the same cycle that the result
// is offered; a finished result waits in its own register, so a new item can be
// accepted while the previous result has not yet been taken.

module scaled_decimal_compare_core #(
    parameter int WIDE_BITS = 224
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [sdc_pkg::MANT_LOW_BITS-1:0]       a_mant_low,
    input  logic [sdc_pkg::MANT_HIGH_BITS-1:0]      a_mant_high,
    input  logic [sdc_pkg::SCALE_BITS-1:0]          a_scale,
    input  logic                                    a_negative,
    input  logic [sdc_pkg::MANT_LOW_BITS-1:0]       b_mant_low,
    input  logic [sdc_pkg::MANT_HIGH_BITS-1:0]      b_mant_high,
    input  logic [sdc_pkg::SCALE_BITS-1:0]          b_scale,
    input  logic                                    b_negative,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [1:0]                              order
);

    sdc_pkg::state_t     state_reg, state_next;
    sdc_pkg::dp_ctrl_t   dp_ctrl;
    sdc_pkg::dp_status_t dp_status;
    sdc_pkg::order_t     order_reg, order_next;
    sdc_pkg::order_t     order_calc;
    logic                out_valid_reg, out_valid_next;
    logic                in_accept;
    logic                out_free;
    logic                finish;

    sdc_align_dp #(
        .WIDE_BITS (WIDE_BITS)
    ) u_align_dp (
        .clk         (clk),
        .ctrl        (dp_ctrl),
        .a_mant_low  (a_mant_low),
        .a_mant_high (a_mant_high),
        .a_scale     (a_scale),
        .a_negative  (a_negative),
        .b_mant_low  (b_mant_low),
        .b_mant_high (b_mant_high),
        .b_scale     (b_scale),
        .b_negative  (b_negative),
        .status      (dp_status)
    );

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish    = (state_reg == sdc_pkg::ST_FINISH) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sdc_pkg::ST_ALIGN;
                end
            end
            sdc_pkg::ST_ALIGN:
            begin
                if (dp_status.aligned)
                begin
                    state_next = sdc_pkg::ST_FINISH;
                end
            end
            sdc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = sdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_stall     = 1'b1;
        dp_ctrl.load = 1'b0;
        dp_ctrl.step = 1'b0;
        unique case (state_reg)
            sdc_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                dp_ctrl.load = in_valid;
            end
            sdc_pkg::ST_ALIGN:
            begin
                dp_ctrl.step = !dp_status.aligned;
            end
            sdc_pkg::ST_FINISH:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Differing signs decide at once; otherwise the magnitude order decides,
    // reversed when both operands are negative.
    always_comb
    begin
        if (dp_status.a_neg != dp_status.b_neg)
        begin
            order_calc = dp_status.a_neg ? sdc_pkg::ORDER_LESS : sdc_pkg::ORDER_GREATER;
        end
        else if (dp_status.mag_eq)
        begin
            order_calc = sdc_pkg::ORDER_EQUAL;
        end
        else if (dp_status.mag_lt ^ dp_status.a_neg)
        begin
            order_calc = sdc_pkg::ORDER_LESS;
        end
        else
        begin
            order_calc = sdc_pkg::ORDER_GREATER;
        end
    end

    always_comb
    begin
        order_next     = order_reg;
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            order_next     = order_calc;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg <= order_next;
    end

    assign out_valid = out_valid_reg;
    assign order     = order_reg;

    // An accepted transfer always starts the alignment.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == sdc_pkg::ST_ALIGN))
    else $error("accepted item did not start alignment");

    // The scales must still match when the result is formed.
    a_finish_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdc_pkg::ST_FINISH) |-> dp_status.aligned)
    else $error("result formed on unaligned operands");

    // A new result only appears straight out of the finishing state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sdc_pkg::ST_FINISH))
    else $error("result offered without a finished item");

endmodule
